// ===== rtl/smv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_pkg
// Shared constants, codes and handshake structs of the shifted
// matrix-vector product block.
// ----------------------------------------------------------------------------
package smv_pkg;

  localparam int DEF_MAX_DIM = 16;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 16;
  localparam int SIZE_W  = 5;
  localparam int SUM_W   = 40;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_WRITE_MATRIX = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_VECTOR = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IN_USE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL_SHIFT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET  = 5'd16;
  localparam logic [VAL_W-1:0]  SHIFT_RESET = 16'd0;

  typedef struct packed {
    logic mat_we;
    logic vec_we;
    logic issue;
    logic first;
    logic last_col;
    logic last_row;
    logic diag;
  } smv_cmd_t;

  typedef struct packed {
    logic result_valid;
    logic result_last;
  } smv_stat_t;

endpackage

// ===== rtl/smv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module smv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/smv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_ctrl
// Controller: decodes items, walks the row and column counters of a
// compute run and waits for the last result before going idle.
// ----------------------------------------------------------------------------
module smv_ctrl
  import smv_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int IW = $clog2(MAX_DIM)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [IDX_W-1:0]  row_index,
  input  logic [IDX_W-1:0]  column_index,
  input  logic [SIZE_W-1:0] size_in_use,
  output smv_cmd_t          cmd_o,
  output logic [IW-1:0]     row_o,
  output logic [IW-1:0]     col_o,
  input  smv_stat_t         stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t        state_r;
  logic [IW-1:0] row_r;
  logic [IW-1:0] col_r;
  logic [IW-1:0] last_r;
  logic          accept;
  logic          row_ok;
  logic          col_ok;
  logic [IW-1:0] last_nxt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign row_ok = int'(row_index) < MAX_DIM;
  assign col_ok = int'(column_index) < MAX_DIM;

  always_comb begin
    if (int'(size_in_use) > MAX_DIM) begin
      last_nxt = IW'(MAX_DIM - 1);
    end else begin
      last_nxt = IW'(size_in_use - 5'd1);
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mat_we   = accept && (operation == OP_WRITE_MATRIX) && row_ok && col_ok;
    cmd_o.vec_we   = accept && (operation == OP_WRITE_VECTOR) && row_ok;
    cmd_o.issue    = (state_r == ST_RUN);
    cmd_o.first    = (col_r == '0);
    cmd_o.last_col = (col_r == last_r);
    cmd_o.last_row = (row_r == last_r);
    cmd_o.diag     = (row_r == col_r);
  end

  assign row_o = row_r;
  assign col_o = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      last_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (operation == OP_COMPUTE) && (size_in_use != '0)) begin
            row_r   <= '0;
            col_r   <= '0;
            last_r  <= last_nxt;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (col_r == last_r) begin
            col_r <= '0;
            if (row_r == last_r) begin
              state_r <= ST_DRAIN;
            end else begin
              row_r <= row_r + 1'b1;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (stat_i.result_valid && stat_i.result_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat_i.result_valid |-> (state_r != ST_IDLE))
    else $error("result emitted while idle");

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((row_r <= last_r) && (col_r <= last_r)))
    else $error("row or column counter beyond active size");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_i.result_valid && stat_i.result_last) |=> (state_r == ST_IDLE))
    else $error("controller still busy after last result");

endmodule

// ===== rtl/smv_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smv_datapath
// Matrix and vector stores, diagonal shift, two multipliers and the
// direct and transposed accumulators.
// ----------------------------------------------------------------------------
module smv_datapath
  import smv_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM,
  localparam int IW = $clog2(MAX_DIM)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  smv_cmd_t                cmd_i,
  input  logic [IW-1:0]           row_i,
  input  logic [IW-1:0]           col_i,
  input  logic [IDX_W-1:0]        wr_row,
  input  logic [IDX_W-1:0]        wr_col,
  input  logic signed [VAL_W-1:0] entry_value,
  input  logic signed [VAL_W-1:0] diagonal_shift,
  output logic [IDX_W-1:0]        result_index,
  output logic signed [SUM_W-1:0] direct_sum,
  output logic signed [SUM_W-1:0] transposed_sum,
  output logic                    last_result,
  output smv_stat_t               stat_o
);

  localparam int OPA_W  = VAL_W + 1;
  localparam int PROD_W = OPA_W + VAL_W;
  localparam int MDEPTH = 1 << (2 * IW);

  logic [2*IW-1:0]  mat_waddr;
  logic [VAL_W-1:0] a_dir;
  logic [VAL_W-1:0] a_tr;
  logic [VAL_W-1:0] x_val;

  smv_cmd_t      s1_r;
  logic [IW-1:0] s1_row_r;
  smv_cmd_t      s2_r;
  logic [IW-1:0] s2_row_r;

  logic signed [OPA_W-1:0]  opa_dir;
  logic signed [OPA_W-1:0]  opa_tr;
  logic signed [OPA_W-1:0]  shift_ext;
  logic signed [PROD_W-1:0] prod_dir_r;
  logic signed [PROD_W-1:0] prod_tr_r;
  logic signed [SUM_W-1:0]  acc_dir_r;
  logic signed [SUM_W-1:0]  acc_tr_r;
  logic signed [SUM_W-1:0]  base_dir;
  logic signed [SUM_W-1:0]  base_tr;
  logic                     out_valid_r;
  logic                     out_last_r;
  logic [IW-1:0]            out_row_r;

  assign mat_waddr = {IW'(wr_row), IW'(wr_col)};

  smv_ram #(.WIDTH(VAL_W), .DEPTH(MDEPTH)) u_mat_dir (
    .clk   (clk),
    .we    (cmd_i.mat_we),
    .waddr (mat_waddr),
    .wdata (entry_value),
    .raddr ({row_i, col_i}),
    .rdata (a_dir)
  );

  smv_ram #(.WIDTH(VAL_W), .DEPTH(MDEPTH)) u_mat_tr (
    .clk   (clk),
    .we    (cmd_i.mat_we),
    .waddr (mat_waddr),
    .wdata (entry_value),
    .raddr ({col_i, row_i}),
    .rdata (a_tr)
  );

  smv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_vec (
    .clk   (clk),
    .we    (cmd_i.vec_we),
    .waddr (IW'(wr_row)),
    .wdata (entry_value),
    .raddr (col_i),
    .rdata (x_val)
  );

  // The diagonal entry carries the shift, so both sums see -shift*x[i].
  assign shift_ext = {diagonal_shift[VAL_W-1], diagonal_shift};

  always_comb begin
    opa_dir = {a_dir[VAL_W-1], a_dir};
    opa_tr  = {a_tr[VAL_W-1], a_tr};
    if (s1_r.diag) begin
      opa_dir = opa_dir - shift_ext;
      opa_tr  = opa_tr - shift_ext;
    end
  end

  always_comb begin
    if (s2_r.first) begin
      base_dir = '0;
      base_tr  = '0;
    end else begin
      base_dir = acc_dir_r;
      base_tr  = acc_tr_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_row_r   <= row_i;
    s2_row_r   <= s1_row_r;
    prod_dir_r <= opa_dir * $signed(x_val);
    prod_tr_r  <= opa_tr * $signed(x_val);
    if (s2_r.issue) begin
      acc_dir_r <= base_dir + {{(SUM_W-PROD_W){prod_dir_r[PROD_W-1]}}, prod_dir_r};
      acc_tr_r  <= base_tr + {{(SUM_W-PROD_W){prod_tr_r[PROD_W-1]}}, prod_tr_r};
      out_row_r <= s2_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      s1_r        <= cmd_i;
      s2_r        <= s1_r;
      out_valid_r <= s2_r.issue && s2_r.last_col;
      out_last_r  <= s2_r.issue && s2_r.last_col && s2_r.last_row;
    end
  end

  assign result_index        = IDX_W'(out_row_r);
  assign direct_sum          = acc_dir_r;
  assign transposed_sum      = acc_tr_r;
  assign last_result         = out_last_r;
  assign stat_o.result_valid = out_valid_r;
  assign stat_o.result_last  = out_last_r;

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last marker without a result");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result follows the last result of a run");

  a_no_write_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.issue || s2_r.issue) |-> !(cmd_i.mat_we || cmd_i.vec_we))
    else $error("store written while a run is in flight");

endmodule

// ===== rtl/shifted_matrix_vector_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifted_matrix_vector_product
// Computes (A - shift*I)x and (A^T - shift*I)x from stored A and x.
// ----------------------------------------------------------------------------
// A matrix or vector write leaves busy low.
// A compute item issues one product pair per cycle, row by row; the result
// of each row passes the RAM read, product and accumulator registers.
// Busy drops in the cycle after the last result.
// Reset sets size_in_use to 16 and diagonal_shift to 0; stores are unset.
// Results are strobed by out_valid for one cycle and cannot be stalled.
module shifted_matrix_vector_product
  import smv_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [IDX_W-1:0]        in_row_index,
  input  logic [IDX_W-1:0]        in_column_index,
  input  logic signed [VAL_W-1:0] in_entry_value,
  output logic                    out_valid,
  output logic [IDX_W-1:0]        out_result_index,
  output logic signed [SUM_W-1:0] out_direct_sum,
  output logic signed [SUM_W-1:0] out_transposed_sum,
  output logic                    out_last_result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data
);

  localparam int IW = $clog2(MAX_DIM);

  logic [SIZE_W-1:0]        size_in_use_r;
  logic signed [VAL_W-1:0]  diagonal_shift_r;
  smv_cmd_t                 cmd;
  smv_stat_t                stat;
  logic [IW-1:0]            row;
  logic [IW-1:0]            col;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_in_use_r    <= SIZE_RESET;
      diagonal_shift_r <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_IN_USE:    size_in_use_r    <= cfg_data[SIZE_W-1:0];
        CFG_DIAGONAL_SHIFT: diagonal_shift_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  smv_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (in_operation),
    .row_index    (in_row_index),
    .column_index (in_column_index),
    .size_in_use  (size_in_use_r),
    .cmd_o        (cmd),
    .row_o        (row),
    .col_o        (col),
    .stat_i       (stat)
  );

  smv_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .row_i          (row),
    .col_i          (col),
    .wr_row         (in_row_index),
    .wr_col         (in_column_index),
    .entry_value    (in_entry_value),
    .diagonal_shift (diagonal_shift_r),
    .result_index   (out_result_index),
    .direct_sum     (out_direct_sum),
    .transposed_sum (out_transposed_sum),
    .last_result    (out_last_result),
    .stat_o         (stat)
  );

  assign out_valid = stat.result_valid;

endmodule

// ===== sim/shifted_matrix_vector_product_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifted_matrix_vector_product_tb
// Loads matrix and vector entries, starts compute runs at several sizes and
// shifts, and compares every strobed row result with an independent predictor.
// ----------------------------------------------------------------------------
import smv_pkg::*;

typedef struct {
  logic [IDX_W-1:0]        index;
  logic signed [SUM_W-1:0] direct;
  logic signed [SUM_W-1:0] transposed;
  logic                    is_last;
} row_result_t;

class product_checker;
  localparam int DIM = DEF_MAX_DIM;

  logic signed [VAL_W-1:0] matrix_q [DIM][DIM];
  logic signed [VAL_W-1:0] vector_q [DIM];
  logic [SIZE_W-1:0]       size_q;
  logic signed [VAL_W-1:0] shift_q;
  row_result_t             pending_rows [$];
  int                      errors;

  function new();
    foreach (matrix_q[i, j]) matrix_q[i][j] = '0;
    foreach (vector_q[i]) vector_q[i] = '0;
    size_q  = SIZE_RESET;
    shift_q = SHIFT_RESET;
    errors  = 0;
  endfunction

  function int pending();
    return pending_rows.size();
  endfunction

  function void note_config(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    if (idx == CFG_SIZE_IN_USE) size_q = data[SIZE_W-1:0];
    else if (idx == CFG_DIAGONAL_SHIFT) shift_q = data;
  endfunction

  function void predict_rows();
    int          n;
    longint      base;
    longint      dsum;
    longint      tsum;
    row_result_t r;
    n = (size_q > DIM) ? DIM : size_q;
    for (int i = 0; i < n; i++) begin
      base = -(longint'(shift_q) * longint'(vector_q[i]));
      dsum = base;
      tsum = base;
      for (int j = 0; j < n; j++) begin
        dsum += longint'(matrix_q[i][j]) * longint'(vector_q[j]);
        tsum += longint'(matrix_q[j][i]) * longint'(vector_q[j]);
      end
      r.index      = IDX_W'(i);
      r.direct     = dsum[SUM_W-1:0];
      r.transposed = tsum[SUM_W-1:0];
      r.is_last    = (i == n - 1);
      pending_rows.push_back(r);
    end
  endfunction

  function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                          logic [IDX_W-1:0] col, logic [VAL_W-1:0] val);
    case (op)
      OP_WRITE_MATRIX: matrix_q[row][col] = val;
      OP_WRITE_VECTOR: vector_q[row] = val;
      OP_COMPUTE:      predict_rows();
      default: ;
    endcase
  endfunction

  function void report_mismatch(string field, logic signed [SUM_W-1:0] want,
                                logic signed [SUM_W-1:0] got);
    errors++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endfunction

  function void check_result(logic [IDX_W-1:0] idx, logic signed [SUM_W-1:0] dsum,
                             logic signed [SUM_W-1:0] tsum, logic last_flag);
    row_result_t want;
    if (pending_rows.size() == 0) begin
      errors++;
      $display("%0t: result at index %0d with nothing pending", $time, idx);
      return;
    end
    want = pending_rows.pop_front();
    if (idx !== want.index) report_mismatch("result_index", want.index, idx);
    if (dsum !== want.direct) report_mismatch("direct_sum", want.direct, dsum);
    if (tsum !== want.transposed)
      report_mismatch("transposed_sum", want.transposed, tsum);
    if (last_flag !== want.is_last)
      report_mismatch("last_result", want.is_last, last_flag);
  endfunction

  function void report_leftover();
    if (pending_rows.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_rows.size());
    end
  endfunction
endclass

module shifted_matrix_vector_product_tb;
  localparam int DIM = DEF_MAX_DIM;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_operation = OP_WRITE_MATRIX;
  logic [IDX_W-1:0]     in_row_index = '0;
  logic [IDX_W-1:0]     in_column_index = '0;
  logic [VAL_W-1:0]     in_entry_value = '0;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_result_index;
  logic signed [SUM_W-1:0] out_direct_sum;
  logic signed [SUM_W-1:0] out_transposed_sum;
  logic                 out_last_result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  product_checker sb = new();

  bit matrix_written [DIM][DIM];
  bit vector_written [DIM];
  int cur_size = SIZE_RESET;
  int burst_left = 0;
  int items_sent = 0;

  shifted_matrix_vector_product #(.MAX_DIM(DIM)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_row_index       (in_row_index),
    .in_column_index    (in_column_index),
    .in_entry_value     (in_entry_value),
    .out_valid          (out_valid),
    .out_result_index   (out_result_index),
    .out_direct_sum     (out_direct_sum),
    .out_transposed_sum (out_transposed_sum),
    .out_last_result    (out_last_result),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_result_index, out_direct_sum, out_transposed_sum,
                        out_last_result);
      if (start && !busy)
        sb.note_item(in_operation, in_row_index, in_column_index, in_entry_value);
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
    end
  end

  function automatic int active_size();
    return (cur_size > DIM) ? DIM : cur_size;
  endfunction

  function automatic logic [VAL_W-1:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic pace_gap();
    int gap;
    gap = $urandom_range(1, 6);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                             : $urandom_range(1, 8);
  endtask

  task automatic drive_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val);
    if (burst_left == 0) pace_gap();
    burst_left--;
    @(negedge clk);
    start           = 1'b1;
    in_operation    = op;
    in_row_index    = row;
    in_column_index = col;
    in_entry_value  = val;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input int size, input logic [VAL_W-1:0] shift);
    logic [VAL_W-1:0] word;
    drain();
    repeat (active_size() * active_size() + 8) @(posedge clk);
    word = VAL_W'($urandom);
    word[SIZE_W-1:0] = SIZE_W'(size);
    cfg_write(CFG_SIZE_IN_USE, word);
    cfg_write(CFG_DIAGONAL_SHIFT, shift);
    cur_size = size;
  endtask

  task automatic write_matrix(input int row, input int col, input logic [VAL_W-1:0] val);
    drive_item(OP_WRITE_MATRIX, IDX_W'(row), IDX_W'(col), val);
    matrix_written[row][col] = 1'b1;
  endtask

  task automatic write_vector(input int idx, input logic [VAL_W-1:0] val);
    drive_item(OP_WRITE_VECTOR, IDX_W'(idx), IDX_W'($urandom), val);
    vector_written[idx] = 1'b1;
  endtask

  // Every entry a run will read must have been written first.
  task automatic compute();
    int n;
    n = active_size();
    for (int i = 0; i < n; i++) begin
      if (!vector_written[i]) write_vector(i, rand_entry());
      for (int j = 0; j < n; j++)
        if (!matrix_written[i][j]) write_matrix(i, j, rand_entry());
    end
    drive_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic random_sequence();
    int n;
    int writes;
    int row;
    int col;
    n = active_size();
    writes = $urandom_range(0, (n == 0) ? 3 : 2 * n);
    repeat (writes) begin
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        row = $urandom_range(0, n - 1);
        col = $urandom_range(0, n - 1);
      end else begin
        row = $urandom_range(0, DIM - 1);
        col = $urandom_range(0, DIM - 1);
      end
      case ($urandom_range(0, 11))
        0:       drive_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        1, 2, 3: write_vector(row, rand_entry());
        default: write_matrix(row, col, rand_entry());
      endcase
    end
    if ($urandom_range(0, 7) == 0) drain();
    compute();
  endtask

  initial begin
    int sizes [$];
    int phase;
    int goal;
    int phase_end;
    int waited;
    sizes = '{3, 5, 0, 2, 16, 4, 31, 1, 6, 3, 7, 2};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_config(1, 16'h8000);
    write_matrix(0, 0, 16'h8000);
    write_vector(0, 16'h8000);
    compute();
    write_matrix(0, 0, 16'h7FFF);
    compute();
    drive_item(OP_UNUSED, 4'hF, 4'hF, 16'hFFFF);
    write_vector(0, 16'h7FFF);
    compute();
    set_config(2, 16'h7FFF);
    write_matrix(0, 1, 16'h7FFF);
    write_matrix(1, 0, 16'h8000);
    write_matrix(1, 1, 16'h8000);
    write_vector(1, 16'h8000);
    write_matrix(15, 15, 16'h5A5A);
    write_vector(15, 16'hA5A5);
    compute();
    set_config(0, 16'h0100);
    compute();
    write_vector(2, 16'h0001);
    compute();

    goal = items_sent + 260;
    phase = 0;
    while (items_sent < goal) begin
      set_config(sizes[phase % sizes.size()], rand_entry());
      phase_end = items_sent + 24;
      while (items_sent < phase_end) random_sequence();
      phase++;
    end

    @(negedge clk);
    start = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (active_size() * active_size() + 8) @(posedge clk);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end
endmodule
